[rtl/dudc_pkg.sv]
// Package for the debounced up/down counter with seven-segment scan: types, defaults, segment map.
package dudc_pkg;

    localparam int DEFAULT_NUM_DIGITS  = 4;
    localparam int DEFAULT_MAX_COUNT   = 9999;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [31:0] WRAP_TOP       = 32'hFFFF_FFFE;
    localparam logic [31:0] WRAP_GUARD_MS  = 32'd500;

    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_UP   = 2'd1,
        OP_DOWN = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    // One strobe per event kind, valid only in the cycle an event is processed.
    typedef struct packed {
        logic scan;
        logic up;
        logic down;
    } dudc_evt_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

[rtl/dudc_press_unit.sv]
// Press filter: debounce window, saturating binary counter and BCD digit copy.
module dudc_press_unit #(
    parameter int NUM_DIGITS = dudc_pkg::DEFAULT_NUM_DIGITS,
    parameter int MAX_COUNT  = dudc_pkg::DEFAULT_MAX_COUNT,
    localparam int CW = $clog2(MAX_COUNT + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dudc_pkg::dudc_evt_t         evt,
    input  logic [31:0]                 time_ms,
    input  logic [15:0]                 debounce_ms,
    output logic                        taken,
    output logic [CW-1:0]               counter,
    output logic [NUM_DIGITS-1:0][3:0]  digits
);
    import dudc_pkg::*;

    logic [31:0]                last_press_reg;
    logic [CW-1:0]              counter_reg, counter_next;
    logic [NUM_DIGITS-1:0][3:0] digit_reg, digit_next;
    logic [31:0]                since;
    logic [31:0]                guard;
    logic                       pass;
    logic                       step_up;
    logic                       step_down;
    logic                       carry;

    assign since = time_ms - last_press_reg;
    assign guard = WRAP_TOP - time_ms + last_press_reg;
    assign pass  = (since > {16'd0, debounce_ms}) && (guard > WRAP_GUARD_MS);
    assign taken = (evt.up || evt.down) && pass;

    assign step_up   = taken && evt.up && (counter_reg < CW'(MAX_COUNT));
    assign step_down = taken && evt.down && (counter_reg != '0);

    // Digits track the counter modulo 10^NUM_DIGITS, so a ripple step suffices.
    always_comb
    begin
        counter_next = counter_reg;
        digit_next   = digit_reg;
        carry        = 1'b1;
        if (step_up)
        begin
            counter_next = counter_reg + CW'(1);
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (carry)
                begin
                    if (digit_reg[i] == 4'd9)
                    begin
                        digit_next[i] = 4'd0;
                    end
                    else
                    begin
                        digit_next[i] = digit_reg[i] + 4'd1;
                        carry         = 1'b0;
                    end
                end
            end
        end
        else if (step_down)
        begin
            counter_next = counter_reg - CW'(1);
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (carry)
                begin
                    if (digit_reg[i] == 4'd0)
                    begin
                        digit_next[i] = 4'd9;
                    end
                    else
                    begin
                        digit_next[i] = digit_reg[i] - 4'd1;
                        carry         = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_press_reg <= '0;
            counter_reg    <= '0;
            digit_reg      <= '0;
        end
        else
        begin
            if (taken)
            begin
                last_press_reg <= time_ms;
            end
            counter_reg <= counter_next;
            digit_reg   <= digit_next;
        end
    end

    assign counter = counter_reg;
    assign digits  = digit_reg;

endmodule

[rtl/dudc_scan_unit.sv]
// Scan driver: digit index, held segment pattern and held active-low commons.
module dudc_scan_unit #(
    parameter int NUM_DIGITS = dudc_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        scan,
    input  logic [NUM_DIGITS-1:0][3:0]  digits,
    output logic [7:0]                  segments,
    output logic [3:0]                  digit_select_n
);
    import dudc_pkg::*;

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW+2:0]   idx_wide;
    logic [7:0]      seg_reg;
    logic [3:0]      sel_reg, sel_next;

    assign idx_next = (idx_reg == IW'(NUM_DIGITS - 1)) ? '0 : idx_reg + IW'(1);
    assign idx_wide = {3'd0, idx_reg};

    // Only four commons exist; higher positions keep every digit off.
    assign sel_next = (idx_wide < (IW + 3)'(4)) ? ~(4'b0001 << idx_reg) : 4'hF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            seg_reg <= 8'h00;
            sel_reg <= 4'hF;
        end
        else if (scan)
        begin
            idx_reg <= idx_next;
            seg_reg <= seg_pattern(digits[idx_reg]);
            sel_reg <= sel_next;
        end
    end

    assign segments       = seg_reg;
    assign digit_select_n = sel_reg;

endmodule

[rtl/debounced_updown_counter_7seg_scan_core.sv]
// Top level of the debounced up/down counter with multiplexed seven-segment scan.
//
// Every input beat (scan tick, up press or down press, with a millisecond
// timestamp) yields exactly one result beat, through the input register and
// the state registers; while the output is not stalled the block sustains one
// beat per clock. Each beat makes one pass from the input register through the
// debounce window check (two 32-bit subtract-and-compare paths) into the state
// registers, which double as the result register. A press is taken when the
// time since the last taken press exceeds debounce_ms and the wrap guard
// exceeds 500 ms; it then steps the counter, saturating at 0 and MAX_COUNT,
// and a BCD copy of the counter steps alongside, so no division is needed.
// A scan tick shows the next digit on its active-low common with the decimal
// point dark. A held input beat waits only while a finished result is stalled
// and the input register is already full. Write debounce_ms while idle only.
module debounced_updown_counter_7seg_scan_core #(
    parameter int NUM_DIGITS = dudc_pkg::DEFAULT_NUM_DIGITS,
    parameter int MAX_COUNT  = dudc_pkg::DEFAULT_MAX_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] time_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  segments,
    output logic [3:0]  digit_select_n,
    output logic [13:0] count_value,
    output logic        press_taken,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import dudc_pkg::*;

    localparam int CW = $clog2(MAX_COUNT + 1);

    // Input register
    logic        in_valid_reg, in_valid_next;
    opcode_t     op_reg;
    logic [31:0] time_reg;

    // Result handshake and the one result field not held as state
    logic        out_valid_reg, out_valid_next;
    logic        taken_reg;

    logic [15:0] debounce_reg;

    logic                       advance;
    logic                       accept;
    logic                       fire;
    dudc_evt_t                  evt;
    logic                       taken;
    logic [CW-1:0]              counter;
    logic [CW+13:0]             counter_wide;
    logic [NUM_DIGITS-1:0][3:0] digits;

    // Advance the pipe whenever the result slot is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign fire     = in_valid_reg && advance;

    assign evt.scan = fire && (op_reg == OP_SCAN);
    assign evt.up   = fire && (op_reg == OP_UP);
    assign evt.down = fire && (op_reg == OP_DOWN);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            taken_reg     <= 1'b0;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                taken_reg <= taken;
            end
            if (cfg_we)
            begin
                debounce_reg <= cfg_wdata;
            end
        end
    end

    // Payload: load on acceptance only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode_t'(opcode);
            time_reg <= time_ms;
        end
    end

    dudc_press_unit #(
        .NUM_DIGITS (NUM_DIGITS),
        .MAX_COUNT  (MAX_COUNT)
    ) u_press (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .time_ms     (time_reg),
        .debounce_ms (debounce_reg),
        .taken       (taken),
        .counter     (counter),
        .digits      (digits)
    );

    dudc_scan_unit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan           (evt.scan),
        .digits         (digits),
        .segments       (segments),
        .digit_select_n (digit_select_n)
    );

    // Drop counter bits above the 14-bit field.
    assign counter_wide = {14'd0, counter};
    assign count_value  = counter_wide[13:0];
    assign out_valid    = out_valid_reg;
    assign press_taken  = taken_reg;

    // Counter never leaves its saturation range.
    assert property (@(posedge clk) disable iff (!rst_n)
        counter <= CW'(MAX_COUNT))
        else $error("counter above MAX_COUNT");

    // At most one digit common is driven low.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(~digit_select_n))
        else $error("more than one digit common active");

    // A taken press always comes from a button beat, never from a scan tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        taken |-> (evt.up || evt.down))
        else $error("press taken without a button beat");

    // Input backpressure only while the input register and the result slot are both full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipe");

endmodule
